// ----- hdl/fixed_region_free_list_allocator_top_assert.svh -----
// Assertion macros shared by the allocator RTL.
`ifndef FIXED_REGION_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define FIXED_REGION_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FRFL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FRFL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/frfl_pkg.sv -----
// Types, constants and microcode program of the free-list block allocator.
package frfl_pkg;

   // Sizing
   localparam int STACK_DEPTH  = 1024;
   localparam int PAGE_BYTES   = 4096;
   localparam int MIN_REGION   = 16;
   localparam int REGION_ALIGN = 16;
   localparam int ADDR_BITS    = 48;
   localparam int TOTAL_LIMIT  = 1048576;
   localparam int CSR_RESET    = 16;

   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int BS_W  = 17;
   localparam int LIM_W = BS_W + 1;
   localparam int TOT_W = 21;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_NO_MEMORY = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Request and response beats
   typedef struct packed {
      logic                 op;
      logic [15:0]          request_size;
      logic [ADDR_BITS-1:0] address;
      logic                 page_valid;
      logic [ADDR_BITS-1:0] page_base;
   } req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] block_address;
      status_type           status;
      logic                 page_consumed;
      logic [15:0]          block_size;
      logic [10:0]          free_blocks;
      logic [TOT_W-1:0]     total_blocks;
   } rsp_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Microcode
   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type S_IDLE      = 4'd0;
   localparam step_type S_DISPATCH  = 4'd1;
   localparam step_type S_PUSH      = 4'd2;
   localparam step_type S_POP       = 4'd3;
   localparam step_type S_POP_RESP  = 4'd4;
   localparam step_type S_CARVE     = 4'd5;
   localparam step_type S_CARVE_END = 4'd6;
   localparam step_type S_FULL      = 4'd7;
   localparam step_type S_BIG       = 4'd8;
   localparam step_type S_NOMEM     = 4'd9;

   typedef enum logic [2:0] {
      SEQ_NEXT     = 3'd0,
      SEQ_JUMP     = 3'd1,
      SEQ_WAIT     = 3'd2,
      SEQ_DISPATCH = 3'd3,
      SEQ_LOOP     = 3'd4
   } seq_type;

   typedef enum logic [2:0] {
      DP_NONE      = 3'd0,
      DP_INIT      = 3'd1,
      DP_PUSH      = 3'd2,
      DP_POP       = 3'd3,
      DP_CARVE     = 3'd4,
      DP_CARVE_END = 3'd5
   } dp_type;

   typedef enum logic [1:0] {
      RSRC_ZERO = 2'd0,
      RSRC_MEM  = 2'd1,
      RSRC_LAST = 2'd2
   } src_type;

   typedef struct packed {
      seq_type    seq;
      step_type   target;
      dp_type     dp;
      logic       resp;
      status_type status;
      src_type    src;
   } ctrl_type;

   // Datapath conditions seen by the sequencer
   typedef struct packed {
      logic is_free;
      logic list_full;
      logic too_large;
      logic list_empty;
      logic page_ok;
      logic carve_last;
   } cond_type;

   // Control store
   function automatic ctrl_type ucode_word(input step_type step);
      ctrl_type w;
      w = '{seq: SEQ_JUMP, target: S_IDLE, dp: DP_NONE, resp: 1'b0,
            status: ST_OK, src: RSRC_ZERO};
      unique case (step)
         S_IDLE: begin
            w.seq    = SEQ_WAIT;
            w.target = S_DISPATCH;
         end
         S_DISPATCH: begin
            w.seq = SEQ_DISPATCH;
            w.dp  = DP_INIT;
         end
         S_PUSH: begin
            w.dp   = DP_PUSH;
            w.resp = 1'b1;
         end
         S_POP: begin
            w.seq = SEQ_NEXT;
            w.dp  = DP_POP;
         end
         S_POP_RESP: begin
            w.resp = 1'b1;
            w.src  = RSRC_MEM;
         end
         S_CARVE: begin
            w.seq    = SEQ_LOOP;
            w.target = S_CARVE_END;
            w.dp     = DP_CARVE;
         end
         S_CARVE_END: begin
            w.dp   = DP_CARVE_END;
            w.resp = 1'b1;
            w.src  = RSRC_LAST;
         end
         S_FULL: begin
            w.resp   = 1'b1;
            w.status = ST_FULL;
         end
         S_BIG: begin
            w.resp   = 1'b1;
            w.status = ST_TOO_LARGE;
         end
         S_NOMEM: begin
            w.resp   = 1'b1;
            w.status = ST_NO_MEMORY;
         end
         default: begin
            w.seq    = SEQ_JUMP;
            w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

   // Requested size raised to the minimum and rounded up to the alignment
   function automatic logic [BS_W-1:0] eff_size(input logic [15:0] req);
      logic [BS_W-1:0] s;
      logic [BS_W-1:0] q;
      s = (req < 16'(MIN_REGION)) ? BS_W'(MIN_REGION) : BS_W'(req);
      q = BS_W'((s + BS_W'(REGION_ALIGN - 1)) / REGION_ALIGN);
      return BS_W'(q * REGION_ALIGN);
   endfunction

   localparam logic [BS_W-1:0] BS_RESET = eff_size(16'(CSR_RESET));

endpackage

// ----- hdl/fixed_region_free_list_allocator_top.sv -----
// Fixed-size block allocator with a LIFO free list, run by a microcoded sequencer.
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+-----------------------------------
//  request  | start, busy, req_data         | beat taken when start && !busy
//  response | rsp_valid, rsp_data           | one-cycle strobe, no back-pressure
//  config   | csr_we, csr_wdata             | written when csr_we is high
//
//  A free passes through the dispatch and push steps, a pop through dispatch,
//  pop and pop-response, and an error through dispatch and an error step; an
//  allocate that refills from a page carves one block (of PAGE_BYTES / block
//  size) per carve step, set by the single write port of the free-list RAM.
//  The response strobe rises in the cycle busy falls.
//  Reset is synchronous; the free-list RAM is not cleared, only its fill count.
//  The receiver cannot stall the response.
module fixed_region_free_list_allocator_top
   import frfl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

`include "fixed_region_free_list_allocator_top_assert.svh"

   ctrl_type ctrl;
   cond_type cond;
   logic     accept;

   logic [BS_W-1:0]      bs_ff, bs_in;
   req_type              req_ff, req_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TOT_W-1:0]     region_ff, region_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [BS_W-1:0]      lim_ff, lim_in;
   logic [ADDR_BITS-1:0] cur_ff, cur_in;
   logic [ADDR_BITS-1:0] last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic [ADDR_BITS-1:0] rdata_ff;

   logic [CNT_W-1:0]     cnt_dec;
   logic [IDX_W-1:0]     pop_idx;
   logic [LIM_W-1:0]     lim_next;
   logic [TOT_W:0]       region_sum;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_wa;
   logic [ADDR_BITS-1:0] mem_wd;
   logic [ADDR_BITS-1:0] mem [STACK_DEPTH];

   assign accept = start && !busy;

   // Sequencer
   frfl_useq u_useq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cond  (cond),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   // Effective block size, recomputed on a register write
   assign bs_in = csr_we ? eff_size(csr_wdata) : bs_ff;

   // Request beat capture
   assign req_in = accept ? req_data : req_ff;

   // Branch conditions
   assign cnt_dec  = count_ff - CNT_W'(1);
   assign pop_idx  = cnt_dec[IDX_W-1:0];
   assign lim_next = {1'b0, lim_ff} + {1'b0, bs_ff};

   always_comb begin
      cond.is_free    = (req_ff.op == OP_FREE);
      cond.list_full  = (count_ff == CNT_W'(STACK_DEPTH));
      cond.too_large  = ({1'b0, req_ff.request_size} > bs_ff);
      cond.list_empty = (count_ff == '0);
      cond.page_ok    = req_ff.page_valid && (bs_ff <= BS_W'(PAGE_BYTES));
      cond.carve_last = (lim_next > LIM_W'(PAGE_BYTES))
                        || (idx_ff == CNT_W'(STACK_DEPTH - 1));
   end

   // Region total, saturating
   assign region_sum = {1'b0, region_ff} + (TOT_W + 1)'(idx_ff);

   // Datapath actions
   always_comb begin
      count_in  = count_ff;
      region_in = region_ff;
      idx_in    = idx_ff;
      lim_in    = lim_ff;
      cur_in    = cur_ff;
      last_in   = last_ff;
      mem_we    = 1'b0;
      mem_wa    = count_ff[IDX_W-1:0];
      mem_wd    = req_ff.address;
      unique case (ctrl.dp)
         DP_NONE: begin
         end
         DP_INIT: begin
            idx_in = '0;
            lim_in = bs_ff;
            cur_in = req_ff.page_base;
         end
         DP_PUSH: begin
            mem_we   = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end
         DP_POP: begin
            count_in = cnt_dec;
         end
         DP_CARVE: begin
            mem_we  = 1'b1;
            mem_wa  = idx_ff[IDX_W-1:0];
            mem_wd  = cur_ff;
            last_in = cur_ff;
            cur_in  = cur_ff + ADDR_BITS'(bs_ff);
            lim_in  = lim_next[BS_W-1:0];
            idx_in  = idx_ff + CNT_W'(1);
         end
         DP_CARVE_END: begin
            count_in  = idx_ff - CNT_W'(1);
            region_in = (region_sum > (TOT_W + 1)'(TOTAL_LIMIT))
                        ? TOT_W'(TOTAL_LIMIT) : region_sum[TOT_W-1:0];
         end
         default: begin
         end
      endcase
   end

   // Response beat
   always_comb begin
      rsp_valid_in          = ctrl.resp;
      rsp_in.status         = ctrl.status;
      rsp_in.page_consumed  = (ctrl.dp == DP_CARVE_END);
      rsp_in.block_size     = (bs_ff > BS_W'(16'hFFFF)) ? 16'hFFFF : bs_ff[15:0];
      rsp_in.free_blocks    = 11'(count_in);
      rsp_in.total_blocks   = region_in;
      case (ctrl.src)
         RSRC_MEM:  rsp_in.block_address = rdata_ff;
         RSRC_LAST: rsp_in.block_address = last_ff;
         default:   rsp_in.block_address = '0;
      endcase
      if (!ctrl.resp) begin
         rsp_in = rsp_ff;
      end
   end

   // Free-list RAM
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.dp == DP_POP) begin
         rdata_ff <= mem[pop_idx];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff        <= BS_RESET;
         count_ff     <= '0;
         region_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bs_ff        <= bs_in;
         count_ff     <= count_in;
         region_ff    <= region_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      idx_ff  <= idx_in;
      lim_ff  <= lim_in;
      cur_ff  <= cur_in;
      last_ff <= last_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `FRFL_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(STACK_DEPTH), "free count beyond stack depth")
   `FRFL_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "accepted beat did not start the sequence")
   `FRFL_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid_ff, !busy, "response strobe while sequence still running")
   `FRFL_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid_ff && rsp_ff.status != ST_OK, rsp_ff.block_address == '0, "error response with non-zero address")
   `FRFL_ASSERT_NOW(a_consumed_ok, clock, reset, rsp_valid_ff && rsp_ff.page_consumed, rsp_ff.status == ST_OK, "page consumed on a failed request")

endmodule

// ----- hdl/frfl_useq.sv -----
// Microcode sequencer: step counter, control store and jump logic.
module frfl_useq
   import frfl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  cond_type cond,
   output ctrl_type ctrl,
   output logic     busy
);

   step_type step_ff;
   step_type step_in;
   step_type disp_step;

   // Control word of the current step
   assign ctrl = ucode_word(step_ff);
   assign busy = (step_ff != S_IDLE);

   // Multiway branch on the request class
   always_comb begin
      if (cond.is_free) begin
         disp_step = cond.list_full ? S_FULL : S_PUSH;
      end else if (cond.too_large) begin
         disp_step = S_BIG;
      end else if (!cond.list_empty) begin
         disp_step = S_POP;
      end else if (cond.page_ok) begin
         disp_step = S_CARVE;
      end else begin
         disp_step = S_NOMEM;
      end
   end

   // Next step
   always_comb begin
      unique case (ctrl.seq)
         SEQ_NEXT:     step_in = step_ff + step_type'(1);
         SEQ_JUMP:     step_in = ctrl.target;
         SEQ_WAIT:     step_in = start ? ctrl.target : step_ff;
         SEQ_DISPATCH: step_in = disp_step;
         SEQ_LOOP:     step_in = cond.carve_last ? ctrl.target : step_ff;
         default:      step_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ----- dv/frfl_grant_checker.sv -----
// Checker for the free-list allocator: predicts each grant beat and compares it on arrival.
module frfl_grant_checker
   import frfl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          grants_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow of the allocator state
   logic [ADDR_BITS-1:0] free_list [STACK_DEPTH];
   int unsigned          free_depth;
   int unsigned          carved_total;
   logic [15:0]          size_request;
   rsp_type              pending_grants [$];

   initial fail_count = 0;

   // One line per failure
   task automatic report_failure(input string what);
      $display("[%0t] grant check: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_field(input string field, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_failure($sformatf("%s got 0x%0h, expected 0x%0h", field, got, want));
   endtask

   // Works out the grant for one request beat and advances the shadow state
   task automatic predict_grant(input req_type beat, output rsp_type grant);
      int unsigned eff;
      int unsigned span;
      grant = '0;
      grant.status = ST_OK;
      eff = (size_request < MIN_REGION) ? MIN_REGION : size_request;
      eff = ((eff + REGION_ALIGN - 1) / REGION_ALIGN) * REGION_ALIGN;
      if (beat.op == OP_FREE) begin
         if (free_depth >= STACK_DEPTH) begin
            grant.status = ST_FULL;
         end else begin
            free_list[free_depth] = beat.address;
            free_depth++;
         end
      end else if (beat.request_size > eff) begin
         grant.status = ST_TOO_LARGE;
      end else begin
         // empty list: carve the offered page, lowest block pushed first
         if (free_depth == 0) begin
            span = PAGE_BYTES / eff;
            if (span > STACK_DEPTH)
               span = STACK_DEPTH;
            if (!beat.page_valid || span == 0) begin
               grant.status = ST_NO_MEMORY;
            end else begin
               for (int unsigned i = 0; i < span; i++)
                  free_list[i] = beat.page_base + ADDR_BITS'(i * eff);
               free_depth = span;
               carved_total += span;
               if (carved_total > TOTAL_LIMIT)
                  carved_total = TOTAL_LIMIT;
               grant.page_consumed = 1'b1;
            end
         end
         if (grant.status == ST_OK) begin
            free_depth--;
            grant.block_address = free_list[free_depth];
         end
      end
      grant.block_size   = (eff > 65535) ? 16'hFFFF : 16'(eff);
      grant.free_blocks  = 11'(free_depth);
      grant.total_blocks = TOT_W'(carved_total);
   endtask

   // Responses are compared before a same-edge request is predicted: they belong to older beats
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         free_depth   = 0;
         carved_total = 0;
         size_request = 16'(CSR_RESET);
         pending_grants.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_grants.size() == 0) begin
               report_failure($sformatf("response with nothing outstanding, address 0x%0h",
                                        rsp_data.block_address));
            end else begin
               want = pending_grants.pop_front();
               check_field("block_address", rsp_data.block_address, want.block_address);
               check_field("status", rsp_data.status, want.status);
               check_field("page_consumed", rsp_data.page_consumed, want.page_consumed);
               check_field("block_size", rsp_data.block_size, want.block_size);
               check_field("free_blocks", rsp_data.free_blocks, want.free_blocks);
               check_field("total_blocks", rsp_data.total_blocks, want.total_blocks);
            end
         end
         if (start && !busy) begin
            predict_grant(req_data, want);
            pending_grants.push_back(want);
         end
         if (csr_we)
            size_request = csr_wdata;
      end
      grants_pending <= pending_grants.size();
   end

endmodule

// ----- dv/fixed_region_free_list_allocator_top_test.sv -----
// Stimulus and verdict for the free-list block allocator, checked by frfl_grant_checker.
module fixed_region_free_list_allocator_top_test
   import frfl_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Longest quiet stretch: a 256-block carve plus gaps and a register write
   localparam int STALL_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;
   int          fail_count;
   int          grants_pending;
   int          idle_cycles = 0;
   logic        steady_run = 1'b0;

   always #1 clock = ~clock;

   fixed_region_free_list_allocator_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   frfl_grant_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .grants_pending (grants_pending)
   );

   // Watchdog: any beat on either channel restarts the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [ADDR_BITS-1:0] rand_addr();
      return ADDR_BITS'({$urandom, $urandom});
   endfunction

   // Unused fields carry noise so that every bit toggles
   function automatic req_type make_alloc(input logic [15:0] size, input logic page_valid,
                                          input logic [ADDR_BITS-1:0] base);
      req_type beat;
      beat.op           = OP_ALLOC;
      beat.request_size = size;
      beat.address      = rand_addr();
      beat.page_valid   = page_valid;
      beat.page_base    = base;
      return beat;
   endfunction

   function automatic req_type make_free(input logic [ADDR_BITS-1:0] addr);
      req_type beat;
      beat.op           = OP_FREE;
      beat.request_size = 16'($urandom);
      beat.address      = addr;
      beat.page_valid   = 1'($urandom);
      beat.page_base    = rand_addr();
      return beat;
   endfunction

   // Mostly page-aligned offers and sizes that fit, with some of anything
   function automatic req_type random_beat(input logic [15:0] size_cfg, input int free_pct);
      logic [15:0]          size;
      logic [ADDR_BITS-1:0] base;
      int                   pick;
      if ($urandom_range(0, 99) < free_pct)
         return make_free(rand_addr());
      pick = $urandom_range(0, 9);
      if (pick < 7)
         size = 16'($urandom_range(0, size_cfg));
      else if (pick < 9)
         size = 16'($urandom);
      else
         size = 16'hFFFF;
      base = rand_addr();
      if ($urandom_range(0, 3) != 0)
         base = base & ~ADDR_BITS'(PAGE_BYTES - 1);
      return make_alloc(size, $urandom_range(0, 3) != 0, base);
   endfunction

   // Inputs change on the falling edge; busy is stable there, so the next rising edge takes the beat
   task automatic send_beat(input req_type beat);
      int gap;
      gap = steady_run ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data = beat;
      start    = 1'b1;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   // Hold off until every grant is back and the block is idle
   task automatic settle();
      start = 1'b0;
      while (grants_pending != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_block_size(input logic [15:0] value);
      settle();
      csr_wdata = value;
      csr_we    = 1'b1;
      @(negedge clock);
      csr_we    = 1'b0;
      @(negedge clock);
   endtask

   task automatic run_phase(input logic [15:0] size_cfg, input int beats, input int free_pct);
      write_block_size(size_cfg);
      for (int i = 0; i < beats; i++) begin
         if (i % 32 == 0)
            steady_run = ($urandom_range(0, 3) == 0);
         send_beat(random_beat(size_cfg, free_pct));
      end
      steady_run = 1'b0;
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Reset block size: empty list with no page, and oversized requests
      send_beat(make_alloc(16'd0, 1'b0, rand_addr()));
      send_beat(make_alloc(16'd17, 1'b1, 48'h0000_0001_0000));
      send_beat(make_alloc(16'hFFFF, 1'b1, 48'h0000_0002_0000));

      // Largest block: bigger than a page, so a refill yields nothing
      write_block_size(16'hFFFF);
      send_beat(make_alloc(16'hFFFF, 1'b1, 48'h0000_0003_0000));
      send_beat(make_alloc(16'd0, 1'b0, rand_addr()));
      send_beat(make_free(48'h0));
      send_beat(make_alloc(16'hFFFF, 1'b0, rand_addr()));
      send_beat(make_alloc(16'd100, 1'b1, 48'h0000_0004_0000));

      // One block per page, at the top of the address space
      write_block_size(16'd4096);
      send_beat(make_alloc(16'd4096, 1'b1, 48'hFFFF_FFFF_F000));
      send_beat(make_free(48'hFFFF_FFFF_FFFF));
      send_beat(make_alloc(16'd4096, 1'b0, rand_addr()));

      // Just over a page once aligned
      write_block_size(16'd4097);
      send_beat(make_alloc(16'd0, 1'b1, 48'h0000_0005_0000));

      // Zero request raised to the minimum; carve wraps past the top address
      write_block_size(16'd0);
      send_beat(make_alloc(16'd16, 1'b1, 48'hFFFF_FFFF_FF00));
      send_beat(make_free(48'hFFFF_FFFF_FFFF));
      send_beat(make_free(48'h0));
      send_beat(make_alloc(16'd0, 1'b0, rand_addr()));
      send_beat(make_alloc(16'd16, 1'b0, rand_addr()));
      send_beat(make_alloc(16'd17, 1'b1, rand_addr()));

      // Mixed traffic over several block sizes
      run_phase(16'd2048, 45, 40);
      run_phase(16'd1, 45, 35);
      run_phase(16'($urandom_range(0, 4200)), 45, 40);
      run_phase(16'd17, 45, 30);
      run_phase(16'($urandom), 45, 40);
      run_phase(16'($urandom_range(0, 600)), 45, 35);

      // Frees only, more than the stack holds, so the list overflows
      run_phase(16'd16, 1030, 100);

      settle();
      repeat (8) @(negedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
